// File: src/timer_and_interrupt_controller_defines.svh
// Assertion macros shared by the timer and interrupt controller RTL.
// Depends on nothing; the asserting file must have clk and rst_n in scope.
`ifndef TIMER_AND_INTERRUPT_CONTROLLER_DEFINES_SVH
`define TIMER_AND_INTERRUPT_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define TAC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tac assertion failed");

// Checked at every edge, reset included.
`define TAC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tac assertion failed");

`else

`define TAC_ASSERT(label, prop)
`define TAC_ASSERT_ALWAYS(label, prop)

`endif

`endif

// File: src/tac_pkg.sv
// Package for the timer and interrupt controller: widths, codes, constants,
// the timer period table and the structs passed between modules. No dependencies.
package tac_pkg;

    localparam int DATA_W       = 8;
    localparam int PC_W         = 16;
    localparam int VEC_W        = 7;
    localparam int OP_W         = 3;
    localparam int SEL_W        = 3;
    localparam int CODE_W       = 3;
    localparam int CLK_W        = 8;
    localparam int DIV_CD_W     = 10;
    localparam int TIM_CD_W     = 12;
    localparam int SERVICE_BITS = 5;
    localparam int IRQ_IDX_W    = 3;

    localparam int TAC_ENABLE_BIT = 2;
    localparam int TIMER_IRQ_BIT  = 2;

    localparam logic signed [DIV_CD_W-1:0] DIV_RELOAD  = 10'sd255;
    localparam logic signed [TIM_CD_W-1:0] TIMER_RESET = 12'sd1024;
    localparam logic [VEC_W-1:0]           VECTOR_BASE = 7'h40;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_READ    = 3'd2,
        OP_SERVICE = 3'd3,
        OP_RAISE   = 3'd4
    } op_t;

    typedef enum logic [SEL_W-1:0] {
        REG_DIV  = 3'd0,
        REG_TIMA = 3'd1,
        REG_TMA  = 3'd2,
        REG_TAC  = 3'd3,
        REG_IF   = 3'd4,
        REG_IE   = 3'd5,
        REG_IME  = 3'd6
    } reg_sel_t;

    // Register writes aimed at the timer block.
    typedef struct packed {
        logic              clr_div;
        logic              wr_tima;
        logic              wr_tma;
        logic              wr_tac;
        logic [DATA_W-1:0] data;
    } timer_wr_t;

    typedef struct packed {
        logic [DATA_W-1:0] div;
        logic [DATA_W-1:0] tima;
        logic [DATA_W-1:0] tma;
        logic [DATA_W-1:0] tac;
    } timer_regs_t;

    // Control for the interrupt block for one request.
    typedef struct packed {
        logic              wr_if;
        logic              wr_ie;
        logic              wr_ime;
        logic              raise;
        logic              service;
        logic [CODE_W-1:0] code;
        logic [DATA_W-1:0] data;
    } irq_ctl_t;

    typedef struct packed {
        logic [DATA_W-1:0] if_flags;
        logic [DATA_W-1:0] ie_mask;
        logic              ime;
    } irq_regs_t;

    typedef struct packed {
        logic             take;
        logic [VEC_W-1:0] vector;
    } irq_svc_t;

    // Timer reload period selected by control bits 1:0.
    function automatic logic signed [TIM_CD_W-1:0] timer_period(input logic [1:0] rate);
        logic signed [TIM_CD_W-1:0] p;
        case (rate)
            2'd0:    p = 12'sd1024;
            2'd1:    p = 12'sd16;
            2'd2:    p = 12'sd64;
            default: p = 12'sd256;
        endcase
        return p;
    endfunction

endpackage

// File: src/tac_if.sv
// Channel interfaces of the timer and interrupt controller: command and response.
// Depends on tac_pkg for field widths.
interface tac_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [tac_pkg::OP_W-1:0]     operation;
    logic [tac_pkg::SEL_W-1:0]    reg_select;
    logic [tac_pkg::DATA_W-1:0]   write_data;
    logic [tac_pkg::CLK_W-1:0]    clocks;
    logic [tac_pkg::CODE_W-1:0]   interrupt_code;
    logic [tac_pkg::PC_W-1:0]     current_pc;

    modport source (
        output valid, operation, reg_select, write_data, clocks, interrupt_code,
               current_pc,
        input  ready
    );
    modport sink (
        input  valid, operation, reg_select, write_data, clocks, interrupt_code,
               current_pc,
        output ready
    );
endinterface

interface tac_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tac_pkg::DATA_W-1:0]   read_data;
    logic                         take_interrupt;
    logic [tac_pkg::VEC_W-1:0]    vector_address;
    logic [tac_pkg::PC_W-1:0]     return_pc;
    logic                         timer_overflow;

    modport source (
        output valid, read_data, take_interrupt, vector_address, return_pc,
               timer_overflow,
        input  ready
    );
    modport sink (
        input  valid, read_data, take_interrupt, vector_address, return_pc,
               timer_overflow,
        output ready
    );
endinterface

// File: src/tac_timer.sv
// Divider and timer: countdowns, DIV, TIMA, TMA and TAC registers.
// Depends on tac_pkg.
module tac_timer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick,
    input  logic [tac_pkg::CLK_W-1:0]  clocks,
    input  tac_pkg::timer_wr_t         wr,
    output tac_pkg::timer_regs_t       regs,
    output logic                       overflow
);
    import tac_pkg::*;

    logic [DATA_W-1:0]          div_reg, div_next;
    logic [DATA_W-1:0]          tima_reg, tima_next;
    logic [DATA_W-1:0]          tma_reg, tma_next;
    logic [DATA_W-1:0]          tac_reg, tac_next;
    logic signed [DIV_CD_W-1:0] div_cd_reg, div_cd_next;
    logic signed [TIM_CD_W-1:0] tim_cd_reg, tim_cd_next;
    logic signed [DIV_CD_W-1:0] div_cd_dec;
    logic signed [TIM_CD_W-1:0] tim_cd_dec;

    assign div_cd_dec = div_cd_reg - $signed({2'b00, clocks});
    assign tim_cd_dec = tim_cd_reg - $signed({4'b0000, clocks});

    // Tick update and register writes; only one of them happens per request.
    always_comb
    begin
        div_next    = div_reg;
        tima_next   = tima_reg;
        tma_next    = tma_reg;
        tac_next    = tac_reg;
        div_cd_next = div_cd_reg;
        tim_cd_next = tim_cd_reg;
        overflow    = 1'b0;

        if (tick)
        begin
            div_cd_next = div_cd_dec;
            if (div_cd_dec <= 0)
            begin
                div_cd_next = div_cd_dec + DIV_RELOAD;
                div_next    = div_reg + 8'd1;
            end
            if (tac_reg[TAC_ENABLE_BIT])
            begin
                tim_cd_next = tim_cd_dec;
                if (tim_cd_dec <= 0)
                begin
                    tim_cd_next = timer_period(tac_reg[1:0]);
                    if (tima_reg == 8'hFF)
                    begin
                        tima_next = tma_reg;
                        overflow  = 1'b1;
                    end
                    else
                    begin
                        tima_next = tima_reg + 8'd1;
                    end
                end
            end
        end

        if (wr.clr_div)
        begin
            div_next = '0;
        end
        if (wr.wr_tima)
        begin
            tima_next = wr.data;
        end
        if (wr.wr_tma)
        begin
            tma_next = wr.data;
        end
        if (wr.wr_tac)
        begin
            tac_next = wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg    <= '0;
            tima_reg   <= '0;
            tma_reg    <= '0;
            tac_reg    <= '0;
            div_cd_reg <= DIV_RELOAD;
            tim_cd_reg <= TIMER_RESET;
        end
        else
        begin
            div_reg    <= div_next;
            tima_reg   <= tima_next;
            tma_reg    <= tma_next;
            tac_reg    <= tac_next;
            div_cd_reg <= div_cd_next;
            tim_cd_reg <= tim_cd_next;
        end
    end

    assign regs.div  = div_reg;
    assign regs.tima = tima_reg;
    assign regs.tma  = tma_reg;
    assign regs.tac  = tac_reg;

endmodule

// File: src/tac_irq.sv
// Interrupt flags, enable mask, master enable and the service priority picker.
// Depends on tac_pkg.
module tac_irq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tac_pkg::irq_ctl_t    ctl,
    input  logic                 timer_ovf,
    output tac_pkg::irq_regs_t   regs,
    output tac_pkg::irq_svc_t    svc
);
    import tac_pkg::*;

    logic [DATA_W-1:0]       if_reg, if_next;
    logic [DATA_W-1:0]       ie_reg, ie_next;
    logic                    ime_reg, ime_next;
    logic [SERVICE_BITS-1:0] pend;
    logic                    found;
    logic [IRQ_IDX_W-1:0]    idx;

    // Lowest pending and enabled flag among the serviceable ones.
    always_comb
    begin
        pend  = if_reg[SERVICE_BITS-1:0] & ie_reg[SERVICE_BITS-1:0];
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < SERVICE_BITS; i++)
        begin
            if (!found && pend[i])
            begin
                found = 1'b1;
                idx   = IRQ_IDX_W'(i);
            end
        end
    end

    assign svc.take   = ctl.service && ime_reg && found;
    assign svc.vector = svc.take ? (VECTOR_BASE + VEC_W'({idx, 3'b000})) : '0;

    // Flag and enable updates.
    always_comb
    begin
        if_next  = if_reg;
        ie_next  = ie_reg;
        ime_next = ime_reg;

        if (timer_ovf)
        begin
            if_next[TIMER_IRQ_BIT] = 1'b1;
        end
        if (ctl.wr_if)
        begin
            if_next = ctl.data;
        end
        if (ctl.wr_ie)
        begin
            ie_next = ctl.data;
        end
        if (ctl.wr_ime)
        begin
            ime_next = ctl.data[0];
        end
        if (ctl.raise)
        begin
            if_next = if_reg | (8'd1 << ctl.code);
        end
        if (svc.take)
        begin
            if_next  = if_reg & ~(8'd1 << idx);
            ime_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            if_reg  <= '0;
            ie_reg  <= '0;
            ime_reg <= 1'b0;
        end
        else
        begin
            if_reg  <= if_next;
            ie_reg  <= ie_next;
            ime_reg <= ime_next;
        end
    end

    assign regs.if_flags = if_reg;
    assign regs.ie_mask  = ie_reg;
    assign regs.ime      = ime_reg;

endmodule

// File: src/timer_and_interrupt_controller.sv
// Top level of the timer and interrupt controller: input register, decode,
// result register. Depends on tac_pkg, tac_if, tac_timer, tac_irq and the defines header.
//
//   Channel  Role   Carries
//   cmd      sink   operation, reg_select, write_data, clocks, interrupt_code, current_pc
//   rsp      source read_data, take_interrupt, vector_address, return_pc, timer_overflow
//
// A request is captured in the input register, executed against the timer and
// interrupt state once the result register is free, and its response is loaded into the result register.
// One request per cycle is sustained unless the response stalls; the state update of each
// request is one pass of subtract-and-compare logic, so the next request sees it at once.
// Reset clears all state and both valid flags. A stalled response holds the result
// register; the input register still accepts one more request behind it.
`include "timer_and_interrupt_controller_defines.svh"

module timer_and_interrupt_controller (
    input  logic      clk,
    input  logic      rst_n,
    tac_cmd_if.sink   cmd,
    tac_rsp_if.source rsp
);
    import tac_pkg::*;

    // Input register.
    logic              in_valid_reg, in_valid_next;
    op_t               op_reg;
    reg_sel_t          sel_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [CLK_W-1:0]  clocks_reg;
    logic [CODE_W-1:0] code_reg;
    logic [PC_W-1:0]   pc_reg;

    // Result register.
    logic              res_valid_reg, res_valid_next;
    logic [DATA_W-1:0] rdata_reg;
    logic              take_reg;
    logic [VEC_W-1:0]  vec_reg;
    logic [PC_W-1:0]   rpc_reg;
    logic              ovf_reg;

    logic              accept;
    logic              advance;
    logic              tick;
    timer_wr_t         timer_wr;
    timer_regs_t       timer_regs;
    logic              timer_ovf;
    irq_ctl_t          irq_ctl;
    irq_regs_t         irq_regs;
    irq_svc_t          irq_svc;
    logic [DATA_W-1:0] rdata;

    // Handshake: the held request executes whenever the result register is free.
    assign advance   = in_valid_reg && (!res_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign accept    = cmd.valid && cmd.ready;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign res_valid_next = advance ? 1'b1 : (rsp.ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Capture the incoming request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(cmd.operation);
            sel_reg    <= reg_sel_t'(cmd.reg_select);
            wdata_reg  <= cmd.write_data;
            clocks_reg <= cmd.clocks;
            code_reg   <= cmd.interrupt_code;
            pc_reg     <= cmd.current_pc;
        end
    end

    // Decode the held request into unit controls.
    always_comb
    begin
        tick             = advance && (op_reg == OP_TICK);
        timer_wr         = '0;
        timer_wr.data    = wdata_reg;
        irq_ctl          = '0;
        irq_ctl.data     = wdata_reg;
        irq_ctl.code     = code_reg;
        irq_ctl.raise    = advance && (op_reg == OP_RAISE);
        irq_ctl.service  = advance && (op_reg == OP_SERVICE);
        if (advance && (op_reg == OP_WRITE))
        begin
            unique case (sel_reg)
                REG_DIV:  timer_wr.clr_div = 1'b1;
                REG_TIMA: timer_wr.wr_tima = 1'b1;
                REG_TMA:  timer_wr.wr_tma  = 1'b1;
                REG_TAC:  timer_wr.wr_tac  = 1'b1;
                REG_IF:   irq_ctl.wr_if    = 1'b1;
                REG_IE:   irq_ctl.wr_ie    = 1'b1;
                REG_IME:  irq_ctl.wr_ime   = 1'b1;
                default:  ;
            endcase
        end
    end

    tac_timer u_timer (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .clocks   (clocks_reg),
        .wr       (timer_wr),
        .regs     (timer_regs),
        .overflow (timer_ovf)
    );

    tac_irq u_irq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (irq_ctl),
        .timer_ovf (timer_ovf),
        .regs      (irq_regs),
        .svc       (irq_svc)
    );

    // Register read selection.
    always_comb
    begin
        rdata = '0;
        if (op_reg == OP_READ)
        begin
            unique case (sel_reg)
                REG_DIV:  rdata = timer_regs.div;
                REG_TIMA: rdata = timer_regs.tima;
                REG_TMA:  rdata = timer_regs.tma;
                REG_TAC:  rdata = timer_regs.tac;
                REG_IF:   rdata = irq_regs.if_flags;
                REG_IE:   rdata = irq_regs.ie_mask;
                REG_IME:  rdata = {{(DATA_W-1){1'b0}}, irq_regs.ime};
                default:  rdata = '0;
            endcase
        end
    end

    // Load the result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rdata_reg <= rdata;
            take_reg  <= irq_svc.take;
            vec_reg   <= irq_svc.vector;
            rpc_reg   <= irq_svc.take ? pc_reg : '0;
            ovf_reg   <= timer_ovf;
        end
    end

    assign rsp.valid          = res_valid_reg;
    assign rsp.read_data      = rdata_reg;
    assign rsp.take_interrupt = take_reg;
    assign rsp.vector_address = vec_reg;
    assign rsp.return_pc      = rpc_reg;
    assign rsp.timer_overflow = ovf_reg;

    // Servicing an interrupt turns the master enable off.
    `TAC_ASSERT(a_service_clears_ime, advance && irq_svc.take |=> !irq_regs.ime)
    // A timer wrap leaves the timer interrupt flag set.
    `TAC_ASSERT(a_ovf_sets_flag, advance && timer_ovf |=> irq_regs.if_flags[TIMER_IRQ_BIT])
    // A held request that cannot execute stays held.
    `TAC_ASSERT(a_hold_request, in_valid_reg && !advance |=> in_valid_reg)
    // No response is offered while in reset.
    `TAC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !rsp.valid)

endmodule

// File: tb/tac_tb_pkg.sv
`timescale 1ns / 1ps
// Response predictor and checker for the timer and interrupt controller testbench.
// Depends on tac_pkg for field widths, operation codes and register selects.
package tac_tb_pkg;
    import tac_pkg::*;

    // Codes that the block decodes as nothing.
    localparam logic [SEL_W-1:0] REG_SPARE      = 3'd7;
    localparam logic [OP_W-1:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0]  OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SEL_W-1:0]  sel;
        logic [DATA_W-1:0] wdata;
        logic [CLK_W-1:0]  clocks;
        logic [CODE_W-1:0] code;
        logic [PC_W-1:0]   pc;
    } tac_request_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              take;
        logic [VEC_W-1:0]  vector;
        logic [PC_W-1:0]   ret_pc;
        logic              overflow;
    } tac_response_t;

    class tac_response_predictor;
        // Shadow copy of the timer and interrupt state.
        logic [DATA_W-1:0] divider;
        int                divider_count;
        int                timer_count;
        logic [DATA_W-1:0] timer_counter;
        logic [DATA_W-1:0] timer_modulo;
        logic [DATA_W-1:0] timer_control;
        logic [DATA_W-1:0] request_flags;
        logic [DATA_W-1:0] enable_mask;
        logic              ime;

        tac_response_t expected_responses[$];
        int failures;
        int requests;
        int responses;
        int wraps;
        int dispatches;

        function new();
            divider       = '0;
            divider_count = int'(DIV_RELOAD);
            timer_count   = int'(TIMER_RESET);
            timer_counter = '0;
            timer_modulo  = '0;
            timer_control = '0;
            request_flags = '0;
            enable_mask   = '0;
            ime           = 1'b0;
            failures      = 0;
            requests      = 0;
            responses     = 0;
            wraps         = 0;
            dispatches    = 0;
        endfunction

        // Countdown reload for each rate setting.
        function int reload_period(logic [1:0] rate);
            case (rate)
                2'd0:    return 1024;
                2'd1:    return 16;
                2'd2:    return 64;
                default: return 256;
            endcase
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        // Apply one accepted request to the shadow state and queue its response.
        function void predict_response(tac_request_t req);
            tac_response_t     rsp;
            logic [DATA_W-1:0] eligible;
            bit                found;
            rsp   = '0;
            found = 1'b0;
            requests++;
            case (req.op)
                OP_TICK: begin
                    divider_count -= int'(req.clocks);
                    if (divider_count <= 0) begin
                        divider_count += int'(DIV_RELOAD);
                        divider++;
                    end
                    if (timer_control[TAC_ENABLE_BIT]) begin
                        timer_count -= int'(req.clocks);
                        if (timer_count <= 0) begin
                            timer_count = reload_period(timer_control[1:0]);
                            if (timer_counter == 8'hFF) begin
                                timer_counter                = timer_modulo;
                                request_flags[TIMER_IRQ_BIT] = 1'b1;
                                rsp.overflow                 = 1'b1;
                                wraps++;
                            end
                            else begin
                                timer_counter++;
                            end
                        end
                    end
                end
                OP_WRITE: begin
                    case (req.sel)
                        REG_DIV:  divider       = '0;
                        REG_TIMA: timer_counter = req.wdata;
                        REG_TMA:  timer_modulo  = req.wdata;
                        REG_TAC:  timer_control = req.wdata;
                        REG_IF:   request_flags = req.wdata;
                        REG_IE:   enable_mask   = req.wdata;
                        REG_IME:  ime           = req.wdata[0];
                        default:  ;
                    endcase
                end
                OP_READ: begin
                    case (req.sel)
                        REG_DIV:  rsp.read_data = divider;
                        REG_TIMA: rsp.read_data = timer_counter;
                        REG_TMA:  rsp.read_data = timer_modulo;
                        REG_TAC:  rsp.read_data = timer_control;
                        REG_IF:   rsp.read_data = request_flags;
                        REG_IE:   rsp.read_data = enable_mask;
                        REG_IME:  rsp.read_data = {{(DATA_W-1){1'b0}}, ime};
                        default:  rsp.read_data = '0;
                    endcase
                end
                OP_SERVICE: begin
                    // Lowest pending and enabled request wins; bits 5 to 7 never do.
                    eligible = request_flags & enable_mask;
                    if (ime) begin
                        for (int i = 0; i < SERVICE_BITS; i++) begin
                            if (!found && eligible[i]) begin
                                found            = 1'b1;
                                ime              = 1'b0;
                                request_flags[i] = 1'b0;
                                rsp.take         = 1'b1;
                                rsp.vector       = VECTOR_BASE + VEC_W'(8 * i);
                                rsp.ret_pc       = req.pc;
                                dispatches++;
                            end
                        end
                    end
                end
                OP_RAISE: begin
                    request_flags[req.code] = 1'b1;
                end
                default: ;
            endcase
            expected_responses.push_back(rsp);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        // Compare an accepted response with the oldest outstanding prediction.
        function void check_response(tac_response_t got);
            tac_response_t want;
            if (expected_responses.size() == 0) begin
                $error("response %h arrived with no request outstanding", got);
                failures++;
                return;
            end
            want = expected_responses.pop_front();
            responses++;
            compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
            compare_field("take_interrupt", 32'(want.take), 32'(got.take));
            compare_field("vector_address", 32'(want.vector), 32'(got.vector));
            compare_field("return_pc", 32'(want.ret_pc), 32'(got.ret_pc));
            compare_field("timer_overflow", 32'(want.overflow), 32'(got.overflow));
        endfunction
    endclass

endpackage

// File: tb/tb_timer_and_interrupt_controller.sv
`timescale 1ns / 1ps
// Top-level testbench of the timer and interrupt controller: clock, reset, request
// driver and response checker. Depends on tac_pkg, tac_if, tac_tb_pkg and the RTL.
module tb_timer_and_interrupt_controller;
    import tac_pkg::*;
    import tac_tb_pkg::*;

    localparam int RANDOM_REQUESTS = 1420;
    localparam int CALM_TAIL       = 200;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 10;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   cycle_count;

    tac_cmd_if cmd_ch ();
    tac_rsp_if rsp_ch ();

    tac_response_predictor model = new();

    timer_and_interrupt_controller dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Response side: check each accepted response and stall in random bursts.
    initial
    begin
        int  stall_left;
        tac_response_t got;
        stall_left   = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.read_data = rsp_ch.read_data;
                got.take      = rsp_ch.take_interrupt;
                got.vector    = rsp_ch.vector_address;
                got.ret_pc    = rsp_ch.return_pc;
                got.overflow  = rsp_ch.timer_overflow;
                model.check_response(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Present one request, possibly after a random gap, and wait for acceptance.
    task automatic send_request(input tac_request_t req);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.operation      <= req.op;
        cmd_ch.reg_select     <= req.sel;
        cmd_ch.write_data     <= req.wdata;
        cmd_ch.clocks         <= req.clocks;
        cmd_ch.interrupt_code <= req.code;
        cmd_ch.current_pc     <= req.pc;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        model.predict_response(req);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                         input logic [DATA_W-1:0] wdata, input logic [CLK_W-1:0] clocks,
                         input logic [CODE_W-1:0] code, input logic [PC_W-1:0] pc);
        tac_request_t req;
        req = '{op: op, sel: sel, wdata: wdata, clocks: clocks, code: code, pc: pc};
        send_request(req);
    endtask

    // Stop sending until every outstanding response has come back.
    task automatic drain_responses();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (model.pending() != 0) @(posedge clk);
    endtask

    // Random request with all fields random, biased towards counter wraps and
    // dispatchable interrupts so the deeper paths are reached often.
    function automatic tac_request_t random_request();
        tac_request_t req;
        int           pick;
        req.op     = OP_TICK;
        req.sel    = SEL_W'($urandom_range(0, 7));
        req.wdata  = DATA_W'($urandom);
        req.clocks = CLK_W'($urandom);
        req.code   = CODE_W'($urandom_range(0, 7));
        req.pc     = PC_W'($urandom);
        pick       = $urandom_range(0, 99);
        if (pick < 36) begin
            req.op = OP_TICK;
        end
        else if (pick < 56) begin
            req.op = OP_WRITE;
            if (req.sel == REG_TIMA && $urandom_range(0, 1) == 0)
                req.wdata = DATA_W'($urandom_range(240, 255));
            if (req.sel == REG_TAC && $urandom_range(0, 3) != 0)
                req.wdata[TAC_ENABLE_BIT] = 1'b1;
            if (req.sel == REG_IME && $urandom_range(0, 3) != 0)
                req.wdata[0] = 1'b1;
        end
        else if (pick < 70) begin
            req.op = OP_READ;
        end
        else if (pick < 84) begin
            req.op = OP_SERVICE;
        end
        else if (pick < 96) begin
            req.op = OP_RAISE;
        end
        else begin
            req.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        return req;
    endfunction

    // Main sequence.
    initial
    begin
        cycle_count           = 0;
        idle_on               = 1'b1;
        rst_n                 <= 1'b0;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.operation      <= OP_TICK;
        cmd_ch.reg_select     <= REG_DIV;
        cmd_ch.write_data     <= '0;
        cmd_ch.clocks         <= '0;
        cmd_ch.interrupt_code <= '0;
        cmd_ch.current_pc     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Counter wrap at the fast rate; the control write leaves the reset
        // countdown of 1024 in place, so five full ticks are needed first.
        issue(OP_WRITE, REG_TIMA, 8'hFF, 8'h00, 3'd0, 16'h0000);
        issue(OP_WRITE, REG_TMA, 8'hA5, 8'hFF, 3'd7, 16'hFFFF);
        issue(OP_WRITE, REG_TAC, 8'hFD, 8'h00, 3'd0, 16'h0000);
        repeat (5) issue(OP_TICK, REG_DIV, 8'h00, 8'hFF, 3'd0, 16'h0000);
        issue(OP_TICK, REG_DIV, 8'hFF, 8'h00, 3'd7, 16'hFFFF);
        issue(OP_READ, REG_TIMA, 8'h00, 8'h00, 3'd0, 16'h0000);

        // Any divider write clears it.
        issue(OP_WRITE, REG_DIV, 8'h5A, 8'h00, 3'd0, 16'h0000);
        issue(OP_READ, REG_DIV, 8'h00, 8'h00, 3'd0, 16'h0000);

        // Master enable takes bit 0 only; service with it off does nothing.
        issue(OP_WRITE, REG_IE, 8'hFF, 8'h00, 3'd0, 16'h0000);
        issue(OP_WRITE, REG_IME, 8'h01, 8'h00, 3'd0, 16'h0000);
        issue(OP_WRITE, REG_IME, 8'hFE, 8'h00, 3'd0, 16'h0000);
        issue(OP_SERVICE, REG_DIV, 8'h00, 8'h00, 3'd0, 16'h1234);

        // Lowest enabled request goes first, then the timer request.
        issue(OP_RAISE, REG_DIV, 8'h00, 8'h00, 3'd7, 16'h0000);
        issue(OP_RAISE, REG_DIV, 8'h00, 8'h00, 3'd0, 16'h0000);
        issue(OP_WRITE, REG_IME, 8'hFF, 8'h00, 3'd0, 16'h0000);
        issue(OP_SERVICE, REG_DIV, 8'h00, 8'h00, 3'd0, 16'hFFFF);
        issue(OP_WRITE, REG_IME, 8'h01, 8'h00, 3'd0, 16'h0000);
        issue(OP_SERVICE, REG_DIV, 8'h00, 8'h00, 3'd0, 16'h0000);
        issue(OP_READ, REG_IME, 8'h00, 8'h00, 3'd0, 16'h0000);

        // Requests in bits 5 to 7 are never serviced.
        issue(OP_WRITE, REG_IF, 8'hE0, 8'h00, 3'd0, 16'h0000);
        issue(OP_WRITE, REG_IME, 8'h01, 8'h00, 3'd0, 16'h0000);
        issue(OP_SERVICE, REG_DIV, 8'h00, 8'h00, 3'd0, 16'hBEEF);

        // Unused register select and unused operation.
        issue(OP_WRITE, REG_SPARE, 8'hFF, 8'h00, 3'd0, 16'h0000);
        issue(OP_READ, REG_SPARE, 8'h00, 8'h00, 3'd0, 16'h0000);
        issue(OP_SPARE_LAST, REG_SPARE, 8'hFF, 8'hFF, 3'd7, 16'hFFFF);

        drain_responses();

        // Random traffic, with calm stretches and a final part without idling.
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i >= RANDOM_REQUESTS - CALM_TAIL)
                idle_on = 1'b0;
            else if (i % 150 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (i == RANDOM_REQUESTS / 2)
                drain_responses();
            send_request(random_request());
        end

        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (model.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d requests over all operation codes and register selects; %0d checked.",
                 model.requests, model.responses);
        $display("Saw %0d timer wraps and %0d interrupts dispatched, with stalls on both sides.",
                 model.wraps, model.dispatches);
        if (model.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
